// ===== src/toaf_pkg.sv =====
// Shared constants and codes of the tracked object alarm block.
`timescale 1ns / 1ps

package toaf_pkg;

  // Default geometry and precision.
  localparam int COORD_BITS_DEF     = 12;
  localparam int TICK_BITS_DEF      = 16;
  localparam int DIST_FRAC_BITS_DEF = 4;

  // Fixed widths of the register file and of the travel accumulator.
  localparam int CFG_BITS    = 16;
  localparam int TRAVEL_BITS = 32;

  // Reset values of the two timing registers.
  localparam logic [CFG_BITS-1:0] ACTIVATE_RESET = 16'd5;
  localparam logic [CFG_BITS-1:0] ALARM_RESET    = 16'd10;

  // Register indexes on the write port.
  typedef enum logic {
    CFG_ACTIVATE = 1'b0,
    CFG_ALARM    = 1'b1
  } cfg_idx_t;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RECT  = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  // Tracking phases.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_INIT    = 2'd1,
    PH_ACTIVE  = 2'd2,
    PH_ALARMED = 2'd3
  } phase_t;

  // Events reported with each frame result.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_INIT     = 3'd1,
    EV_ACTIVATE = 3'd2,
    EV_ALARM    = 3'd3,
    EV_RELEASE  = 3'd4
  } event_t;

endpackage

// ===== src/toaf_if.sv =====
// Request and result channel interfaces of the tracked object alarm block.
`timescale 1ns / 1ps

interface toaf_in_if import toaf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_w;
  logic [COORD_BITS-1:0] box_h;
  logic                  frame_end;
  logic                  release_on_miss;

  modport source (
    output valid, op, box_x, box_y, box_w, box_h, frame_end, release_on_miss,
    input  ready
  );
  modport sink (
    input  valid, op, box_x, box_y, box_w, box_h, frame_end, release_on_miss,
    output ready
  );
endinterface

interface toaf_out_if import toaf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             phase;
  logic [2:0]             event_res;
  logic [COORD_BITS-1:0]  track_x;
  logic [COORD_BITS-1:0]  track_y;
  logic [COORD_BITS-1:0]  track_w;
  logic [COORD_BITS-1:0]  track_h;
  logic [TRAVEL_BITS-1:0] travelled;

  modport source (
    output valid, phase, event_res, track_x, track_y, track_w, track_h, travelled,
    input  ready
  );
  modport sink (
    input  valid, phase, event_res, track_x, track_y, track_w, track_h, travelled,
    output ready
  );
endinterface

// ===== src/toaf_isqrt.sv =====
// Bit-serial integer square root unit, one result bit per cycle.
`timescale 1ns / 1ps

module toaf_isqrt import toaf_pkg::*; #(
  parameter int RAD_W = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAD_W-1:0]     radicand,
  output logic                 busy,
  output logic                 done,
  output logic [RAD_W/2-1:0]   root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W-1:0] acc;
  logic [CNT_W-1:0]  cnt;

  logic [ROOT_W+2:0] rem_shift;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_sub;
  logic              take;

  // Restoring step: bring down two radicand bits and try the next root bit.
  assign rem_shift = {rem, rad[RAD_W-1 -: 2]};
  assign trial     = {1'b0, acc, 2'b01};
  assign take      = rem_shift >= trial;
  assign rem_sub   = rem_shift - trial;
  assign root      = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      acc <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      rem <= take ? rem_sub[ROOT_W:0] : rem_shift[ROOT_W:0];
      acc <= {acc[ROOT_W-2:0], take};
    end
  end

endmodule

// ===== src/tracked_object_alarm_fsm.sv =====
// Top level of the tracked object alarm block: phase sequencer and travel meter.
//
//   channel  | role   | accepted when          | payload
//   ---------+--------+------------------------+-------------------------------------
//   item     | sink   | valid & ready          | op, box_x/y/w/h, frame_end, release_on_miss
//   result   | source | valid & ready          | phase, event_res, track_x/y/w/h, travelled
//   wr_*     | write  | wr_en high             | wr_index, wr_data
//
// Ticks and rectangles that do not end a frame are handled in the idle state. A request
// that ends a frame, a last rectangle or an empty frame, passes through the decision and
// the result state when no distance is due; otherwise through the decision, the squaring
// of dx and then of dy, the add, the start of the square-root unit, the wait on that unit
// (one root bit per cycle, then its done flag), and the result state.
// The item channel is ready only while the sequencer waits in its idle state.
// A result waits in an output register; ticks and rectangles keep being accepted
// meanwhile, and only the next frame end stalls until that result has been taken.
// Reset is synchronous and active high; it restores both timing registers to their
// defaults and clears the track, with no clearing pass.
`timescale 1ns / 1ps

module tracked_object_alarm_fsm import toaf_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TICK_BITS      = TICK_BITS_DEF,
  parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  toaf_in_if.sink             item,
  toaf_out_if.source          result,
  input  logic                wr_en,
  input  logic                wr_index,
  input  logic [CFG_BITS-1:0] wr_data
);

  // Centre coordinates carry one extra bit; the squared sum one more again.
  localparam int CTR_W   = COORD_BITS + 1;
  localparam int SQSUM_W = 2 * CTR_W + 1;
  localparam int SQ_W    = SQSUM_W + 2 * DIST_FRAC_BITS;
  localparam int RAD_W   = SQ_W + (SQ_W % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int CMP_W   = (TICK_BITS > CFG_BITS) ? TICK_BITS : CFG_BITS;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_SQX    = 8'b0000_0100,
    S_SQY    = 8'b0000_1000,
    S_SUM    = 8'b0001_0000,
    S_START  = 8'b0010_0000,
    S_ROOT   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Timing registers.
  logic [CFG_BITS-1:0] activate_after;
  logic [CFG_BITS-1:0] alarm_after;

  // Track state.
  phase_t                 phase_reg;
  logic [TICK_BITS-1:0]   since_init;
  logic [TICK_BITS-1:0]   since_active;
  logic [COORD_BITS-1:0]  trk_x, trk_y, trk_w, trk_h;
  logic [COORD_BITS-1:0]  cand_x, cand_y, cand_w, cand_h;
  logic                   cand_valid;
  logic                   first_in_frame;
  logic [TRAVEL_BITS-1:0] travel_acc;

  // Frame-end bookkeeping held across the sequence.
  logic   matched_q;
  logic   release_q;
  event_t event_q;
  logic [CTR_W-1:0] dx_q;
  logic [CTR_W-1:0] dy_q;

  // Shared multiplier datapath.
  logic [CTR_W-1:0]     mul_a;
  logic [2*CTR_W-1:0]   sq_val;
  logic [2*CTR_W-1:0]   prod;
  logic [SQSUM_W-1:0]   sumsq;

  // Square-root unit.
  logic              sqrt_start;
  logic [RAD_W-1:0]  radicand;
  logic              sqrt_busy;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  // Output register.
  logic                   out_valid;
  phase_t                 out_phase;
  event_t                 out_event;
  logic [COORD_BITS-1:0]  out_x, out_y, out_w, out_h;
  logic [TRAVEL_BITS-1:0] out_travel;

  logic accept;
  logic out_free;

  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;

  assign item.ready = (state == S_IDLE);

  // Overlap of the incoming rectangle with the tracked box, positive area required.
  logic [COORD_BITS-1:0] ov_l, ov_t;
  logic [CTR_W-1:0]      trk_r, trk_b, box_r, box_b, ov_r, ov_b;
  logic                  overlap;

  always_comb begin
    trk_r   = {1'b0, trk_x} + {1'b0, trk_w};
    trk_b   = {1'b0, trk_y} + {1'b0, trk_h};
    box_r   = {1'b0, item.box_x} + {1'b0, item.box_w};
    box_b   = {1'b0, item.box_y} + {1'b0, item.box_h};
    ov_l    = (trk_x > item.box_x) ? trk_x : item.box_x;
    ov_t    = (trk_y > item.box_y) ? trk_y : item.box_y;
    ov_r    = (trk_r < box_r) ? trk_r : box_r;
    ov_b    = (trk_b < box_b) ? trk_b : box_b;
    overlap = (ov_r > {1'b0, ov_l}) && (ov_b > {1'b0, ov_t});
  end

  // When idle, the first rectangle of a frame is taken; later, the last overlapping one.
  logic                  take_rect;
  logic                  cand_valid_n;
  logic [COORD_BITS-1:0] cand_w_n, cand_h_n;

  assign take_rect    = (phase_reg == PH_IDLE) ? first_in_frame : overlap;
  assign cand_valid_n = take_rect || cand_valid;
  assign cand_w_n     = take_rect ? item.box_w : cand_w;
  assign cand_h_n     = take_rect ? item.box_h : cand_h;

  // Phase step at a frame end. At most one step per frame; release only on a miss.
  logic   init_due, alarm_due;
  event_t ev;

  assign init_due  = CMP_W'(since_init) > CMP_W'(activate_after);
  assign alarm_due = CMP_W'(since_active) > CMP_W'(alarm_after);

  always_comb begin
    ev = EV_NONE;
    if (!matched_q) begin
      if (phase_reg != PH_IDLE && release_q) begin
        ev = EV_RELEASE;
      end
    end else if (phase_reg == PH_ACTIVE && alarm_due) begin
      ev = EV_ALARM;
    end else if (phase_reg == PH_INIT && init_due) begin
      ev = EV_ACTIVATE;
    end else if (phase_reg == PH_IDLE) begin
      ev = EV_INIT;
    end
  end

  // Centre-to-centre offsets between the tracked box and the chosen rectangle.
  logic [CTR_W-1:0] tcx, tcy, ccx, ccy, dx, dy;

  always_comb begin
    tcx = {1'b0, trk_x} + CTR_W'(trk_w >> 1);
    tcy = {1'b0, trk_y} + CTR_W'(trk_h >> 1);
    ccx = {1'b0, cand_x} + CTR_W'(cand_w >> 1);
    ccy = {1'b0, cand_y} + CTR_W'(cand_h >> 1);
    dx  = (tcx >= ccx) ? tcx - ccx : ccx - tcx;
    dy  = (tcy >= ccy) ? tcy - ccy : ccy - tcy;
  end

  // One multiplier squares dx, then dy.
  assign mul_a  = (state == S_SQX) ? dx_q : dy_q;
  assign sq_val = (2 * CTR_W)'(mul_a) * (2 * CTR_W)'(mul_a);

  assign sqrt_start = (state == S_START);
  assign radicand   = RAD_W'(sumsq) << (2 * DIST_FRAC_BITS);

  // Saturating accumulation of the step distance.
  logic [TRAVEL_BITS:0] travel_sum;
  assign travel_sum = {1'b0, travel_acc} + (TRAVEL_BITS + 1)'(sqrt_root);

  toaf_isqrt #(
    .RAD_W (RAD_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && ((item.op == OP_RECT && item.frame_end) || item.op == OP_EMPTY)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (matched_q && ev != EV_INIT) begin
          state_next = S_SQX;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SQX:   state_next = S_SQY;
      S_SQY:   state_next = S_SUM;
      S_SUM:   state_next = S_START;
      S_START: state_next = S_ROOT;
      S_ROOT: begin
        if (sqrt_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      activate_after <= ACTIVATE_RESET;
      alarm_after    <= ALARM_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_ACTIVATE: activate_after <= wr_data;
        CFG_ALARM:    alarm_after    <= wr_data;
        default:      ;
      endcase
    end
  end

  // Track state, counters, candidate and travel.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_IDLE;
      since_init     <= '0;
      since_active   <= '0;
      trk_x          <= '0;
      trk_y          <= '0;
      trk_w          <= '0;
      trk_h          <= '0;
      cand_x         <= '0;
      cand_y         <= '0;
      cand_w         <= '0;
      cand_h         <= '0;
      cand_valid     <= 1'b0;
      first_in_frame <= 1'b1;
      travel_acc     <= '0;
      matched_q      <= 1'b0;
      release_q      <= 1'b0;
      event_q        <= EV_NONE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.op)
              OP_TICK: begin
                if (phase_reg != PH_IDLE && since_init != '1) begin
                  since_init <= since_init + 1'b1;
                end
                if ((phase_reg == PH_ACTIVE || phase_reg == PH_ALARMED) &&
                    since_active != '1) begin
                  since_active <= since_active + 1'b1;
                end
              end
              OP_RECT: begin
                if (take_rect) begin
                  cand_x <= item.box_x;
                  cand_y <= item.box_y;
                  cand_w <= item.box_w;
                  cand_h <= item.box_h;
                end
                if (item.frame_end) begin
                  // A zero-sized first rectangle never counts as a match.
                  matched_q      <= cand_valid_n && cand_w_n != '0 && cand_h_n != '0;
                  release_q      <= item.release_on_miss;
                  cand_valid     <= 1'b0;
                  first_in_frame <= 1'b1;
                end else begin
                  cand_valid     <= cand_valid_n;
                  first_in_frame <= 1'b0;
                end
              end
              OP_EMPTY: begin
                // Pending rectangles are dropped and the frame ends unmatched.
                matched_q      <= 1'b0;
                release_q      <= item.release_on_miss;
                cand_valid     <= 1'b0;
                first_in_frame <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_DECIDE: begin
          event_q <= ev;
          case (ev)
            EV_RELEASE: begin
              phase_reg    <= PH_IDLE;
              since_init   <= '0;
              since_active <= '0;
              trk_x        <= '0;
              trk_y        <= '0;
              trk_w        <= '0;
              trk_h        <= '0;
              travel_acc   <= '0;
            end
            EV_ALARM: phase_reg <= PH_ALARMED;
            EV_ACTIVATE: begin
              phase_reg    <= PH_ACTIVE;
              since_active <= '0;
            end
            EV_INIT: begin
              // The first detection takes the box and adds no distance.
              phase_reg  <= PH_INIT;
              since_init <= '0;
              trk_x      <= cand_x;
              trk_y      <= cand_y;
              trk_w      <= cand_w;
              trk_h      <= cand_h;
            end
            default: ;
          endcase
        end
        S_ROOT: begin
          if (sqrt_done) begin
            travel_acc <= travel_sum[TRAVEL_BITS] ? '1 : travel_sum[TRAVEL_BITS-1:0];
            trk_x      <= cand_x;
            trk_y      <= cand_y;
            trk_w      <= cand_w;
            trk_h      <= cand_h;
          end
        end
        default: ;
      endcase
    end
  end

  // Offsets and squares need no reset.
  always_ff @(posedge clk) begin
    case (state)
      S_DECIDE: begin
        dx_q <= dx;
        dy_q <= dy;
      end
      S_SQX: prod <= sq_val;
      S_SQY: begin
        prod  <= sq_val;
        sumsq <= SQSUM_W'(prod);
      end
      S_SUM: sumsq <= sumsq + SQSUM_W'(prod);
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_phase  <= phase_reg;
      out_event  <= event_q;
      out_x      <= trk_x;
      out_y      <= trk_y;
      out_w      <= trk_w;
      out_h      <= trk_h;
      out_travel <= travel_acc;
    end
  end

  assign result.valid     = out_valid;
  assign result.phase     = out_phase;
  assign result.event_res = out_event;
  assign result.track_x   = out_x;
  assign result.track_y   = out_y;
  assign result.track_w   = out_w;
  assign result.track_h   = out_h;
  assign result.travelled = out_travel;

`ifndef SYNTHESIS
  // A frame end always occupies the sequencer for at least the next cycle.
  a_frame_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (accept && item.op == OP_EMPTY) |=> !item.ready)
    else $error("item channel ready right after a frame end");

  // The travel meter only grows when a distance is added.
  a_travel_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && sqrt_done) |=> travel_acc >= $past(travel_acc))
    else $error("travel accumulator decreased");

  // The root unit is busy for the whole wait on it.
  a_root_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && !sqrt_done) |-> sqrt_busy)
    else $error("waiting on an idle square-root unit");

  // Reported events agree with the reported phase.
  a_event_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_event == EV_INIT || out_event == EV_RELEASE ||
                   out_event == EV_ALARM)) |->
    ((out_event == EV_INIT && out_phase == PH_INIT) ||
     (out_event == EV_RELEASE && out_phase == PH_IDLE && out_travel == '0) ||
     (out_event == EV_ALARM && out_phase == PH_ALARMED)))
    else $error("result event and phase disagree");
`endif

endmodule
